@@ rtl/core/swis_pkg.sv @@
// Shared types and constants for the stopwatch interval statistics block.
// Holds event kind codes, field widths and the controller/datapath interface.
// No dependencies.
package swis_pkg;

	// Event kinds carried on the input tuser
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_STOP  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Field widths
	localparam int KIND_W  = 2;
	localparam int TS_W    = 32;
	localparam int STAT_W  = 32;
	localparam int MEAN_W  = 40;
	localparam int FRAC_W  = 8;
	localparam int NUM_W   = STAT_W + MEAN_W;
	localparam int OUT_RAW = 2 + 4 * STAT_W + MEAN_W;
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

	// Divider: one quotient bit per cycle
	localparam int DIV_STEPS = MEAN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // latch the accepted request
		logic exec;      // apply the event to the statistics
		logic mul_lo;    // low word of mean times (n-1)
		logic mul_hi;    // high byte of mean times (n-1)
		logic sum;       // form the numerator, seed the divider
		logic div_step;  // one restoring division step
		logic load_out;  // move the statistics into the output register
	} swis_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic stop_go;   // latched event is a stop with an interval open
		logic div_last;  // divider is on its final step
		logic out_free;  // output register can take a new result
	} swis_stat_t;

endpackage

@@ rtl/core/swis_ctrl.sv @@
// Sequencer for the stopwatch statistics: accept, apply, mean update, output.
// Depends on swis_pkg for the command and status structs.
module swis_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swis_pkg::swis_stat_t stat,
	output swis_pkg::swis_cmd_t  cmd
);
	import swis_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_MUL_LO = 3'd2;
	localparam logic [2:0] ST_MUL_HI = 3'd3;
	localparam logic [2:0] ST_SUM    = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_LOAD   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = stat.stop_go ? ST_MUL_LO : ST_LOAD;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_nxt  = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_nxt  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/core/swis_dp.sv @@
// Datapath: statistics registers, 32x32 multiplier, restoring divider, output register.
// Depends on swis_pkg for widths, kind codes and the command and status structs.
module swis_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [swis_pkg::KIND_W-1:0]        in_kind,
	input  logic [swis_pkg::TS_W-1:0]          in_ts,
	input  swis_pkg::swis_cmd_t                cmd,
	output swis_pkg::swis_stat_t               stat,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [swis_pkg::OUT_W-1:0]         out_data
);
	import swis_pkg::*;

	// Latched request
	logic [KIND_W-1:0]    kind_q;
	logic [TS_W-1:0]      ts_q;

	// Architectural statistics
	logic                 running_q;
	logic [TS_W-1:0]      start_q;
	logic [STAT_W-1:0]    count_q;
	logic [STAT_W-1:0]    last_q;
	logic [STAT_W-1:0]    min_q;
	logic [STAT_W-1:0]    max_q;
	logic [MEAN_W-1:0]    mean_q;
	logic                 accepted_q;

	// Mean update working registers
	logic [STAT_W-1:0]    elapsed_q;
	logic [STAT_W-1:0]    mult_q;
	logic [STAT_W-1:0]    divisor_q;
	logic [2*STAT_W-1:0]  prod_lo_q;
	logic [STAT_W+7:0]    prod_hi_q;
	logic [STAT_W-1:0]    rem_q;
	logic [MEAN_W-1:0]    dvd_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Output register
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic [STAT_W-1:0]    elapsed;
	logic [NUM_W-1:0]     num;
	logic [STAT_W:0]      trial;
	logic [STAT_W:0]      diff;
	logic                 qbit;

	assign elapsed = ts_q - start_q;

	// Numerator: mean*(n-1) + elapsed*256, below n*2^40 so it fits in 72 bits
	assign num = {{(NUM_W-2*STAT_W){1'b0}}, prod_lo_q}
		+ {prod_hi_q, {STAT_W{1'b0}}}
		+ {{(NUM_W-STAT_W-FRAC_W){1'b0}}, elapsed_q, {FRAC_W{1'b0}}};

	// Restoring division step
	assign trial = {rem_q, dvd_q[MEAN_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign qbit  = (trial >= {1'b0, divisor_q});

	assign stat.stop_go  = (kind_q == KIND_STOP) && running_q;
	assign stat.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign stat.out_free = !out_valid_q || out_ready;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			ts_q   <= in_ts;
		end
	end

	// Event handling and mean write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			start_q    <= '0;
			count_q    <= '0;
			last_q     <= '0;
			min_q      <= '1;
			max_q      <= '0;
			mean_q     <= '0;
			accepted_q <= 1'b0;
		end else if (cmd.exec) begin
			case (kind_q)
				KIND_START: begin
					if (!running_q) begin
						running_q  <= 1'b1;
						start_q    <= ts_q;
						accepted_q <= 1'b1;
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						accepted_q <= 1'b0;
					end
				end
				KIND_STOP: begin
					if (running_q) begin
						running_q  <= 1'b0;
						last_q     <= elapsed;
						accepted_q <= 1'b1;
						if (elapsed < min_q) begin
							min_q <= elapsed;
						end
						if (elapsed > max_q) begin
							max_q <= elapsed;
						end
					end else begin
						accepted_q <= 1'b0;
					end
				end
				KIND_CLEAR: begin
					running_q  <= 1'b0;
					start_q    <= '0;
					count_q    <= '0;
					last_q     <= '0;
					min_q      <= '1;
					max_q      <= '0;
					mean_q     <= '0;
					accepted_q <= 1'b1;
				end
				default: begin
					accepted_q <= 1'b0;
				end
			endcase
		end else if (cmd.div_step && stat.div_last) begin
			mean_q <= {dvd_q[MEAN_W-2:0], qbit};
		end
	end

	// Mean update: operands, multiplies, numerator, divider
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			elapsed_q <= elapsed;
			mult_q    <= (count_q == '0) ? '0 : count_q - 1'b1;
			divisor_q <= (count_q == '0) ? STAT_W'(1) : count_q;
		end
		if (cmd.mul_lo) begin
			prod_lo_q <= (2*STAT_W)'(mean_q[STAT_W-1:0]) * (2*STAT_W)'(mult_q);
		end
		if (cmd.mul_hi) begin
			prod_hi_q <= (STAT_W+8)'(mean_q[MEAN_W-1:STAT_W]) * (STAT_W+8)'(mult_q);
		end
		if (cmd.sum) begin
			// upper numerator bits are below the divisor, so they seed the remainder
			rem_q     <= num[NUM_W-1:MEAN_W];
			dvd_q     <= num[MEAN_W-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= qbit ? diff[STAT_W-1:0] : trial[STAT_W-1:0];
			dvd_q     <= {dvd_q[MEAN_W-2:0], qbit};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {{(OUT_W-OUT_RAW){1'b0}}, mean_q, max_q, min_q, last_q,
				count_q, running_q, accepted_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/core/stopwatch_interval_statistics.sv @@
// Stopwatch interval statistics: measures start/stop intervals, keeps last/min/max/mean.
// Top level; instantiates swis_ctrl and swis_dp, uses swis_pkg.
//
// Input stream: one request per event. tuser holds the kind (start, stop, clear),
// tdata the 32-bit microsecond timestamp. Output stream: one result per request
// with the accept flag, the measuring flag and all statistics.
// Sequence: start, clear, unused kinds and ignored stops are applied and then loaded
// into the output register; an accepted stop is applied, then goes through the low and
// high multiplies, the numerator add, 40 steps of the bit-serial divider that updates
// the 32.8 mean, and the output load, which waits until the output register is free.
// Throughput: one request at a time; s_axis_tready rises again at the edge that
// loads the result into the output register.
// The next request is taken while the previous result waits in the output register.
// Reset: all statistics return to their clear values (minimum all ones), no
// interval is open and the output register is empty.
// Stall: a held result keeps m_axis_tdata stable; a following result waits in
// the block, and the input stops taking requests until the output drains.
module stopwatch_interval_statistics (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [31:0] timestamp_us
	input  logic [swis_pkg::TS_W-1:0]    s_axis_tdata,
	// [1:0] kind
	input  logic [swis_pkg::KIND_W-1:0]  s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [0] accepted, [1] measuring, [33:2] interval_count, [65:34] last_interval,
	// [97:66] min_interval, [129:98] max_interval, [169:130] mean_interval, rest zero
	output logic [swis_pkg::OUT_W-1:0]   m_axis_tdata
);
	import swis_pkg::*;

	swis_cmd_t  cmd;
	swis_stat_t stat;

	// Sequencer
	swis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Statistics datapath
	swis_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_kind   (s_axis_tuser),
		.in_ts     (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

@@ bench/tb_top.sv @@
// Testbench for stopwatch_interval_statistics: start/stop/clear requests, checked field by
// field against an in-bench predictor of the interval statistics and the 32.8 running mean.
// Depends on swis_pkg and the stopwatch_interval_statistics RTL.
`timescale 1ns / 1ps

module tb_top;
	import swis_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         STALL_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int         TAIL_CYCLES = 60;    // longest latency plus margin

	// One result as the block reports it
	typedef struct packed {
		logic        accepted;
		logic        measuring;
		logic [31:0] interval_count;
		logic [31:0] last_interval;
		logic [31:0] min_interval;
		logic [31:0] max_interval;
		logic [39:0] mean_interval;
	} stat_snapshot_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [TS_W-1:0]     s_axis_tdata = '0;
	logic [KIND_W-1:0]   s_axis_tuser = KIND_START;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;

	// Predicted statistics state
	logic        sw_open = 1'b0;
	logic [31:0] sw_start = '0;
	logic [31:0] sw_count = '0;
	logic [31:0] sw_last = '0;
	logic [31:0] sw_min = '1;
	logic [31:0] sw_max = '0;
	logic [39:0] sw_mean = '0;

	stat_snapshot_t expected_stats[$];
	int             fail_count = 0;
	int             taken_requests = 0;
	bit             idling = 1'b1;
	int             stall_left = 0;
	int             quiet_cycles = 0;

	stopwatch_interval_statistics u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Running mean: (avg*(n-1) + t*256) / n, truncated, n of zero divides by one
	function automatic logic [39:0] next_mean(logic [39:0] avg, logic [31:0] n,
			logic [31:0] t);
		logic [79:0] num;
		logic [79:0] den;
		logic [79:0] quo;
		den = (n == 32'd0) ? 80'd1 : {48'd0, n};
		num = {40'd0, avg} * ((n == 32'd0) ? 80'd0 : {48'd0, n - 32'd1})
			+ ({48'd0, t} << 8);
		quo = num / den;
		return quo[39:0];
	endfunction

	function automatic void clear_stats();
		sw_open  = 1'b0;
		sw_start = '0;
		sw_count = '0;
		sw_last  = '0;
		sw_min   = '1;
		sw_max   = '0;
		sw_mean  = '0;
	endfunction

	// Apply one request to the predicted state and return the expected result
	function automatic stat_snapshot_t apply_event(logic [1:0] kind, logic [31:0] ts);
		stat_snapshot_t r;
		logic [31:0]    elapsed;
		logic           ok;
		ok = 1'b0;
		case (kind)
			KIND_START: begin
				if (!sw_open) begin
					sw_open = 1'b1;
					if (sw_count != 32'hFFFF_FFFF)
						sw_count = sw_count + 32'd1;
					sw_start = ts;
					ok = 1'b1;
				end
			end
			KIND_STOP: begin
				if (sw_open) begin
					elapsed = ts - sw_start;
					sw_last = elapsed;
					sw_mean = next_mean(sw_mean, sw_count, elapsed);
					if (elapsed < sw_min)
						sw_min = elapsed;
					if (elapsed > sw_max)
						sw_max = elapsed;
					sw_open = 1'b0;
					ok = 1'b1;
				end
			end
			KIND_CLEAR: begin
				clear_stats();
				ok = 1'b1;
			end
			default: ;
		endcase
		r.accepted       = ok;
		r.measuring      = sw_open;
		r.interval_count = sw_count;
		r.last_interval  = sw_last;
		r.min_interval   = sw_min;
		r.max_interval   = sw_max;
		r.mean_interval  = sw_mean;
		return r;
	endfunction

	// Send one request; the expectation is queued at the accepting edge
	task automatic send_event(input logic [1:0] kind, input logic [31:0] ts);
		stat_snapshot_t r;
		if (idling && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ts;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = apply_event(kind, ts);
		expected_stats.push_back(r);
		if (r.accepted && kind != KIND_CLEAR)
			taken_requests++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [39:0] want,
			input logic [39:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Random interval length: short, moderate, any, or near full scale
	function automatic logic [31:0] pick_span();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 255);
			1: return $urandom_range(0, 1_000_000);
			2: return $urandom;
			default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
		endcase
	endfunction

	// Extremes and each corner case, in a known order
	task automatic test_directed();
		send_event(KIND_STOP, 32'h0000_0000);        // stop with no interval open
		send_event(KIND_UNUSED, 32'hFFFF_FFFF);      // unused kind while idle
		send_event(KIND_START, 32'hFFFF_FFF0);
		send_event(KIND_START, 32'h0000_0005);       // start while measuring
		send_event(KIND_UNUSED, 32'h1234_5678);      // unused kind while measuring
		send_event(KIND_STOP, 32'h0000_0010);        // timestamp wraps
		send_event(KIND_START, 32'h0000_0000);
		send_event(KIND_STOP, 32'h0000_0000);        // zero-length interval
		send_event(KIND_START, 32'hFFFF_FFFF);
		send_event(KIND_STOP, 32'hFFFF_FFFE);        // full-scale interval
		send_event(KIND_START, 32'hAAAA_AAAA);
		send_event(KIND_STOP, 32'h5555_5555);
		send_event(KIND_CLEAR, 32'hFFFF_FFFF);
		send_event(KIND_START, 32'h1234_5678);
		send_event(KIND_STOP, 32'h1234_5677);        // full scale must not lower the minimum
		send_event(KIND_START, 32'h5555_5555);
		send_event(KIND_CLEAR, 32'h0000_0000);       // clear with an interval open
		send_event(KIND_STOP, 32'h6666_6666);
		send_event(KIND_START, 32'h0000_0001);
		send_event(KIND_STOP, 32'h0000_0101);
		send_event(KIND_START, 32'h8000_0000);
		send_event(KIND_STOP, 32'h7FFF_FFFF);
		wait_drain();
	endtask

	// Mostly start/stop pairs with random content, some stray and unused requests
	task automatic run_traffic(input int n_items, input bit burst_idle);
		logic [31:0] base;
		int          goal;
		int          pick;
		goal = taken_requests + n_items;
		while (taken_requests < goal) begin
			if (burst_idle && ($urandom_range(0, 99) == 0))
				idling = ~idling;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				base = $urandom;
				send_event(KIND_START, base);
				send_event(KIND_STOP, base + pick_span());
			end else if (pick < 88) begin
				send_event(KIND_START, $urandom);
			end else if (pick < 95) begin
				send_event(KIND_STOP, $urandom);
			end else if (pick < 98) begin
				send_event(KIND_UNUSED, $urandom);
			end else begin
				send_event(KIND_CLEAR, $urandom);
			end
		end
		wait_drain();
	endtask

	task automatic test_random_with_idling();
		idling = 1'b1;
		run_traffic(900, 1'b1);
	endtask

	task automatic test_random_back_to_back();
		idling = 1'b0;
		run_traffic(300, 1'b0);
	endtask

	// Output side back-pressure in random bursts while idling is set; otherwise always ready
	always @(posedge clk) begin
		if (!idling) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		stat_snapshot_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_stats.size() == 0) begin
				$error("result with no request outstanding: %0h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_stats.pop_front();
				check_field("accepted", 40'(want.accepted), 40'(m_axis_tdata[0]));
				check_field("measuring", 40'(want.measuring), 40'(m_axis_tdata[1]));
				check_field("interval_count", 40'(want.interval_count),
					40'(m_axis_tdata[33:2]));
				check_field("last_interval", 40'(want.last_interval),
					40'(m_axis_tdata[65:34]));
				check_field("min_interval", 40'(want.min_interval),
					40'(m_axis_tdata[97:66]));
				check_field("max_interval", 40'(want.max_interval),
					40'(m_axis_tdata[129:98]));
				check_field("mean_interval", want.mean_interval, m_axis_tdata[169:130]);
				check_field("padding", 40'd0, 40'(m_axis_tdata[OUT_W-1:170]));
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_with_idling();
		test_random_back_to_back();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_stats.size() != 0) begin
			$error("%0d results never arrived", expected_stats.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
